### hdl/sfp_pkg.sv
package sfp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COORD_W = 6;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned LEN_W   = 16;

    // packed result fields, padded to whole bytes
    localparam int unsigned RES_BITS = BYTE_W + 2 * COORD_W + MODE_W + 2 * COUNT_W;
    localparam int unsigned RES_W    = ((RES_BITS + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] START_BYTE  = 8'h21;  // '!'
    localparam logic [BYTE_W-1:0] KEY_ACK     = 8'h61;  // 'a'
    localparam logic [BYTE_W-1:0] KEY_NACK    = 8'h62;  // 'b'
    localparam logic [BYTE_W-1:0] KEY_MSG     = 8'h63;  // 'c'
    localparam logic [BYTE_W-1:0] ACK_CONFIRM = 8'h41;  // 'A'
    localparam logic [BYTE_W-1:0] COORD_MAX   = 8'd32;
    localparam logic [BYTE_W-1:0] MODE_MAX    = 8'd2;

    typedef enum logic [3:0] {
        PH_HUNT     = 4'd0,
        PH_KEY      = 4'd1,
        PH_LEN_HI   = 4'd2,
        PH_LEN_LO   = 4'd3,
        PH_PAYLOAD  = 4'd4,
        PH_ACK_KEY  = 4'd5,
        PH_ACK_X    = 4'd6,
        PH_ACK_Y    = 4'd7,
        PH_ACK_M    = 4'd8,
        PH_NACK_KEY = 4'd9
    } phase_t;

    typedef enum logic {
        EV_PAYLOAD = 1'b0,
        EV_ACK     = 1'b1
    } event_kind_t;

    typedef struct packed {
        event_kind_t          event_kind;
        logic [BYTE_W-1:0]    payload_byte;
        logic                 payload_last;
        logic [COORD_W-1:0]   ack_x;
        logic [COORD_W-1:0]   ack_y;
        logic [MODE_W-1:0]    ack_mode;
        logic [COUNT_W-1:0]   acks_seen;
        logic [COUNT_W-1:0]   nacks_seen;
    } result_t;

endpackage

### hdl/serial_ack_frame_parser_core.sv
// A result beat passes from the input register through the parser into the result register, where it shows on m_tvalid.
// Throughput: 1 input beat per cycle while the result side does not stall; one input register
// and one result register bound it, with the frame parser's state update in between.
// Stalls on the result side hold the result register and then the input register.
// Reset (aresetn low, synchronous) returns the parser to hunting for '!', clears
// the ack and nack counters and empties both registers.
module serial_ack_frame_parser_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sfp_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] payload_byte, [13:8] ack_x, [19:14] ack_y, [21:20] ack_mode,
    // [37:22] acks_seen, [53:38] nacks_seen, [55:54] zero
    output logic [sfp_pkg::RES_W-1:0]     m_tdata,
    output logic                          m_tlast,   // payload_last
    output logic                          m_tuser    // [0] event_kind
);

    logic                          in_valid_reg;
    logic [sfp_pkg::BYTE_W-1:0]    in_byte_reg;
    logic                          advance;
    logic                          emit;
    sfp_pkg::result_t              result;
    sfp_pkg::result_t              m_result;

    // Advance the held beat into the parser when the result slot is free or
    // drains this cycle; a beat that makes no result just updates the state.
    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    sfp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .emit    (emit),
        .result  (result)
    );

    sfp_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && emit),
        .result   (result),
        .m_ready  (m_tready),
        .m_valid  (m_tvalid),
        .m_result (m_result)
    );

    // Pack the result beat, lowest field first.
    assign m_tdata = sfp_pkg::RES_W'({m_result.nacks_seen, m_result.acks_seen,
                                      m_result.ack_mode, m_result.ack_y,
                                      m_result.ack_x, m_result.payload_byte});
    assign m_tlast = m_result.payload_last;
    assign m_tuser = m_result.event_kind;

    a_ack_beat_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tlast && m_tdata[7:0] == '0
                                && m_result.ack_mode <= sfp_pkg::MODE_W'(sfp_pkg::MODE_MAX))
        else $error("ack beat carries payload bits or bad mode");

    a_payload_beat_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[21:8] == '0)
        else $error("payload beat carries ack fields");

    a_no_drop_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !(advance && emit))
        else $error("result overwritten while stalled");

endmodule

### hdl/sfp_parser.sv
module sfp_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [sfp_pkg::BYTE_W-1:0]    rx_byte,
    output logic                          emit,
    output sfp_pkg::result_t              result
);

    sfp_pkg::phase_t                    phase_reg, phase_next;
    logic [sfp_pkg::BYTE_W-1:0]         length_high_reg, length_high_next;
    logic [sfp_pkg::LEN_W-1:0]          bytes_left_reg, bytes_left_next;
    logic [sfp_pkg::COORD_W-1:0]        held_x_reg, held_x_next;
    logic [sfp_pkg::COORD_W-1:0]        held_y_reg, held_y_next;
    logic [sfp_pkg::COUNT_W-1:0]        ack_total_reg, ack_total_next;
    logic [sfp_pkg::COUNT_W-1:0]        nack_total_reg, nack_total_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= sfp_pkg::PH_HUNT;
            length_high_reg <= '0;
            bytes_left_reg  <= '0;
            held_x_reg      <= '0;
            held_y_reg      <= '0;
            ack_total_reg   <= '0;
            nack_total_reg  <= '0;
        end else if (step) begin
            phase_reg       <= phase_next;
            length_high_reg <= length_high_next;
            bytes_left_reg  <= bytes_left_next;
            held_x_reg      <= held_x_next;
            held_y_reg      <= held_y_next;
            ack_total_reg   <= ack_total_next;
            nack_total_reg  <= nack_total_next;
        end
    end

    always_comb begin
        phase_next          = phase_reg;
        length_high_next    = length_high_reg;
        bytes_left_next     = bytes_left_reg;
        held_x_next         = held_x_reg;
        held_y_next         = held_y_reg;
        ack_total_next      = ack_total_reg;
        nack_total_next     = nack_total_reg;
        emit                = 1'b0;
        result              = '0;
        result.event_kind   = sfp_pkg::EV_PAYLOAD;

        case (phase_reg)
            sfp_pkg::PH_KEY: begin
                if (rx_byte == sfp_pkg::KEY_ACK) begin
                    ack_total_next = ack_total_reg + 1'b1;
                    phase_next     = sfp_pkg::PH_ACK_KEY;
                end else if (rx_byte == sfp_pkg::KEY_NACK) begin
                    nack_total_next = nack_total_reg + 1'b1;
                    phase_next      = sfp_pkg::PH_NACK_KEY;
                end else if (rx_byte == sfp_pkg::KEY_MSG) begin
                    phase_next = sfp_pkg::PH_LEN_HI;
                end else begin
                    phase_next = sfp_pkg::PH_HUNT;
                end
            end
            sfp_pkg::PH_LEN_HI: begin
                length_high_next = rx_byte;
                phase_next       = sfp_pkg::PH_LEN_LO;
            end
            sfp_pkg::PH_LEN_LO: begin
                bytes_left_next = {length_high_reg, rx_byte};
                phase_next      = sfp_pkg::PH_PAYLOAD;
            end
            sfp_pkg::PH_PAYLOAD: begin
                emit                = 1'b1;
                result.payload_byte = rx_byte;
                // a length of zero streams one byte, same as one
                if (bytes_left_reg > sfp_pkg::LEN_W'(1)) begin
                    bytes_left_next = bytes_left_reg - 1'b1;
                end else begin
                    bytes_left_next     = '0;
                    result.payload_last = 1'b1;
                    phase_next          = sfp_pkg::PH_HUNT;
                end
            end
            sfp_pkg::PH_ACK_KEY: begin
                phase_next = (rx_byte == sfp_pkg::ACK_CONFIRM) ? sfp_pkg::PH_ACK_X
                                                              : sfp_pkg::PH_HUNT;
            end
            sfp_pkg::PH_ACK_X: begin
                if (rx_byte <= sfp_pkg::COORD_MAX) begin
                    held_x_next = rx_byte[sfp_pkg::COORD_W-1:0];
                    phase_next  = sfp_pkg::PH_ACK_Y;
                end else begin
                    phase_next = sfp_pkg::PH_HUNT;
                end
            end
            sfp_pkg::PH_ACK_Y: begin
                if (rx_byte <= sfp_pkg::COORD_MAX) begin
                    held_y_next = rx_byte[sfp_pkg::COORD_W-1:0];
                    phase_next  = sfp_pkg::PH_ACK_M;
                end else begin
                    phase_next = sfp_pkg::PH_HUNT;
                end
            end
            sfp_pkg::PH_ACK_M: begin
                if (rx_byte <= sfp_pkg::MODE_MAX) begin
                    emit              = 1'b1;
                    result.event_kind = sfp_pkg::EV_ACK;
                    result.ack_x      = held_x_reg;
                    result.ack_y      = held_y_reg;
                    result.ack_mode   = rx_byte[sfp_pkg::MODE_W-1:0];
                end
                phase_next = sfp_pkg::PH_HUNT;
            end
            sfp_pkg::PH_NACK_KEY: begin
                phase_next = sfp_pkg::PH_HUNT;
            end
            default: begin
                // hunting, and any stray phase code: clear the frame context
                held_x_next      = '0;
                held_y_next      = '0;
                length_high_next = '0;
                bytes_left_next  = '0;
                phase_next       = (rx_byte == sfp_pkg::START_BYTE) ? sfp_pkg::PH_KEY
                                                                    : sfp_pkg::PH_HUNT;
            end
        endcase

        result.acks_seen  = ack_total_next;
        result.nacks_seen = nack_total_next;
    end

    a_key_after_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == sfp_pkg::PH_KEY |-> length_high_reg == '0 && bytes_left_reg == '0)
        else $error("key phase entered with stale length context");

    a_x_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == sfp_pkg::PH_ACK_Y || phase_reg == sfp_pkg::PH_ACK_M
        |-> held_x_reg <= sfp_pkg::COORD_W'(sfp_pkg::COORD_MAX))
        else $error("held x out of range");

    a_counts_step: assert property (@(posedge aclk) disable iff (!aresetn)
        step && phase_reg != sfp_pkg::PH_KEY |=> $stable(ack_total_reg) && $stable(nack_total_reg))
        else $error("counter moved outside key phase");

endmodule

### hdl/sfp_out_reg.sv
module sfp_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  sfp_pkg::result_t    result,
    input  logic                m_ready,
    output logic                m_valid,
    output sfp_pkg::result_t    m_result
);

    logic               valid_reg;
    sfp_pkg::result_t   result_reg;

    // load only happens when the slot is free or being drained this cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule
